// File: rtl/core/rap_pkg.sv
// Shared types, constants and constant functions of the random arpeggiator note picker.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package rap_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_NOTES_DEF = 16;
	localparam int MAX_SCALE_DEF = 64;
	localparam int KNOB_BITS_DEF = 8;

	// Fixed field widths.
	localparam int NOTE_W = 8;
	localparam int CNT_W  = 5;

	// Operation codes carried in a request.
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_LOAD_NOTE  = 2'd1;
	localparam logic [1:0] OP_LOAD_SCALE = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TEMPO_INC  = 3'd0;
	localparam logic [2:0] CFG_NOTE_COUNT = 3'd1;
	localparam logic [2:0] CFG_SCALE_CNT  = 3'd2;
	localparam logic [2:0] CFG_OCT_THRESH = 3'd3;
	localparam logic [2:0] CFG_PITCH_KNOB = 3'd4;

	// Reset values.
	localparam logic [31:0] TEMPO_INC_RST  = 32'd178957;
	localparam logic [7:0]  PITCH_KNOB_RST = 8'd128;
	localparam logic [31:0] RAND_SEED      = 32'h1234_5678;

	// Largest octave shift of the transpose factor.
	localparam logic [2:0] OCT_SHIFT_MAX = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  slot;
		logic [31:0] load_value;
	} rap_item_t;

	typedef struct packed {
		logic [31:0] frequency;
		logic        octave_up;
		logic        led_on;
	} rap_result_t;

	// Status of the transpose factor unit.
	typedef struct packed {
		logic        busy;
		logic [2:0]  shift_n;
		logic [31:0] mult;
	} rap_gain_t;

	typedef logic [15:0][31:0] rap_root_tab_t;

	function automatic logic [31:0] rap_xorshift(input logic [31:0] x_in);
		logic [31:0] x;
		x = x_in;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	// Floor square root, evaluated at elaboration only.
	function automatic logic [63:0] rap_isqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int k = 0; k < 32; k++) begin
			if (b != '0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Entry i holds 2^(2^-(i+1)) in Q2.30, each root taken from the one before.
	function automatic rap_root_tab_t rap_root_table();
		rap_root_tab_t tab;
		logic [63:0] c;
		c = rap_isqrt(64'h2000_0000_0000_0000);
		for (int i = 0; i < 16; i++) begin
			tab[i] = c[31:0];
			c = rap_isqrt(c << 30);
		end
		return tab;
	endfunction

endpackage

// File: rtl/core/rap_tables.sv
// Note slot and scale frequency memories of the arpeggiator note picker.
// Both are synchronous, one write and one read port, read data registered. Uses rap_pkg.
module rap_tables #(
	parameter int MAX_NOTES = rap_pkg::MAX_NOTES_DEF,
	parameter int MAX_SCALE = rap_pkg::MAX_SCALE_DEF,
	parameter int NA_W      = $clog2(MAX_NOTES),
	parameter int SA_W      = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1
) (
	input  logic                        clk,
	input  logic                        note_we,
	input  logic [NA_W-1:0]             note_waddr,
	input  logic [rap_pkg::NOTE_W-1:0]  note_wdata,
	input  logic                        note_re,
	input  logic [NA_W-1:0]             note_raddr,
	output logic [rap_pkg::NOTE_W-1:0]  note_rdata,
	input  logic                        scale_we,
	input  logic [SA_W-1:0]             scale_waddr,
	input  logic [31:0]                 scale_wdata,
	input  logic                        scale_re,
	input  logic [SA_W-1:0]             scale_raddr,
	output logic [31:0]                 scale_rdata
);

	logic [rap_pkg::NOTE_W-1:0] note_mem [MAX_NOTES];
	logic [31:0]                scale_mem [MAX_SCALE];

	always_ff @(posedge clk) begin
		if (note_we) begin
			note_mem[note_waddr] <= note_wdata;
		end
		if (note_re) begin
			note_rdata <= note_mem[note_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (scale_we) begin
			scale_mem[scale_waddr] <= scale_wdata;
		end
		if (scale_re) begin
			scale_rdata <= scale_mem[scale_raddr];
		end
	end

endmodule

// File: rtl/core/rap_mod.sv
// Remainder unit: 32-bit value modulo a small divisor, four quotient bits per cycle.
// Uses rap_pkg.
module rap_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                value,
	input  logic [rap_pkg::CNT_W-1:0]  divisor,
	output logic                       busy,
	output logic [rap_pkg::CNT_W-1:0]  rem
);

	logic [31:0]               val_q;
	logic [rap_pkg::CNT_W-1:0] rem_q;
	logic [rap_pkg::CNT_W-1:0] div_q;
	logic [2:0]                cnt_q;
	logic                      busy_q;

	logic [31:0]               v_nx;
	logic [rap_pkg::CNT_W-1:0] r_nx;
	logic [rap_pkg::CNT_W:0]   t;

	// Four restoring steps; the remainder always stays below the divisor.
	always_comb begin
		r_nx = rem_q;
		v_nx = val_q;
		t    = '0;
		for (int j = 0; j < 4; j++) begin
			t = {r_nx, v_nx[31]};
			if (t >= {1'b0, div_q}) begin
				r_nx = rap_pkg::CNT_W'(t - {1'b0, div_q});
			end else begin
				r_nx = t[rap_pkg::CNT_W-1:0];
			end
			v_nx = v_nx << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd7;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 3'd1;
			if (cnt_q == 3'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			val_q <= v_nx;
			rem_q <= r_nx;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/rap_gain.sv
// Transpose factor unit: turns the pitch knob into a Q2.30 multiplier and an octave shift.
// Reciprocal multiplication divides by the knob range, then sixteen root multiplies. Uses rap_pkg.
module rap_gain #(
	parameter int KNOB_BITS = rap_pkg::KNOB_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         knob,
	output rap_pkg::rap_gain_t gain
);

	localparam int DW     = KNOB_BITS + 18;
	localparam int KMAX_I = (1 << KNOB_BITS) - 1;
	// The reciprocal is rounded up with a shift of DW + KNOB_BITS, which makes the quotient
	// exact for every dividend below 2^DW.
	localparam int RS     = DW + KNOB_BITS;
	localparam logic [DW:0] RECIP =
		(DW + 1)'(((64'd1 << RS) + 64'(KMAX_I - 1)) / 64'(KMAX_I));
	localparam logic [17:0] HALF = 18'(KMAX_I / 2);
	localparam rap_pkg::rap_root_tab_t ROOT_C = rap_pkg::rap_root_table();

	localparam logic [1:0] G_DONE = 2'd0;
	localparam logic [1:0] G_DIV  = 2'd1;
	localparam logic [1:0] G_MUL  = 2'd2;

	logic [1:0]           st_q;
	logic [3:0]           step_q;
	logic [DW-1:0]        dq_q;
	logic [31:0]          mult_q;

	logic [2*DW:0]        qprod;
	logic [63:0]          prod;
	logic [15:0]          frac;
	logic [2:0]           oct;

	assign qprod = (2 * DW + 1)'(dq_q) * (2 * DW + 1)'(RECIP);
	assign prod  = 64'(mult_q) * 64'(ROOT_C[step_q]);
	assign frac  = dq_q[15:0];
	assign oct   = (dq_q[18:16] > rap_pkg::OCT_SHIFT_MAX) ? rap_pkg::OCT_SHIFT_MAX : dq_q[18:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= G_DONE;
			step_q <= '0;
		end else if (go) begin
			st_q <= G_DIV;
		end else begin
			case (st_q)
				G_DIV: begin
					st_q   <= G_MUL;
					step_q <= '0;
				end
				G_MUL: begin
					if (step_q == 4'd15) begin
						st_q <= G_DONE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: begin
					st_q <= G_DONE;
				end
			endcase
		end
	end

	// The dividend is replaced by its quotient, which then holds the shift and the fraction.
	always_ff @(posedge clk) begin
		if (go) begin
			dq_q <= {KNOB_BITS'(knob), HALF};
		end else if (st_q == G_DIV) begin
			dq_q   <= DW'(qprod[2*DW:RS]);
			mult_q <= 32'h4000_0000;
		end else if (st_q == G_MUL) begin
			if (frac[4'd15 - step_q]) begin
				mult_q <= prod[61:30];
			end
		end
	end

	assign gain.busy    = go || (st_q != G_DONE);
	assign gain.shift_n = oct;
	assign gain.mult    = mult_q;

endmodule

// File: rtl/core/random_arpeggiator_note_picker.sv
// Top level of the random arpeggiator note picker.
// Instantiates rap_tables, rap_mod and rap_gain; types and constants come from rap_pkg.
//
// Usage. Requests arrive on the item channel (valid/ready): a sample tick, a note slot
// load or a scale entry load. Loads, ticks that do not wrap the tempo phase and ticks
// while fewer than two notes are in use are taken without a trigger and give no result.
// A tick that wraps the phase is a trigger: it draws a random number, reduces it modulo
// the note count in the remainder unit, reads the note slot and the scale entry from
// the synchronous memories and scales the frequency; the result is loaded into the
// output register. A note whose scale index is out of range gives no result. While a
// trigger is in flight the item channel is not ready; one trigger is handled at a time.
// The result channel (valid/ready) is fed from an output register, so new requests are
// taken while a result waits. A trigger that finishes while the previous result still
// waits holds in its last step until the receiver takes the old one.
// Configuration writes come on the cfg channel, which is always ready. After reset and
// after each pitch_knob write the transpose factor is recomputed; meanwhile no request
// is accepted. Reset sets the phase, the LED, the generator seed and the configuration
// and control registers to their reset values; the datapath registers are not reset
// and the tables are undefined until loaded.
module random_arpeggiator_note_picker #(
	parameter int MAX_NOTES = rap_pkg::MAX_NOTES_DEF,
	parameter int MAX_SCALE = rap_pkg::MAX_SCALE_DEF,
	parameter int KNOB_BITS = rap_pkg::KNOB_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  rap_pkg::rap_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output rap_pkg::rap_result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int NA_W = $clog2(MAX_NOTES);
	localparam int SA_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	// Trigger sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MOD   = 3'd1;
	localparam logic [2:0] ST_NOTE  = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	// Configuration registers.
	logic [31:0]               tempo_inc_q;
	logic [rap_pkg::CNT_W-1:0] note_count_q;
	logic [6:0]                scale_count_q;
	logic [31:0]               oct_thr_q;
	logic [7:0]                pitch_knob_q;
	logic                      gain_go_q;

	// Block state.
	logic [2:0]  state_q;
	logic [31:0] rnd_q;
	logic [31:0] phase_q;
	logic        led_q;
	logic        result_valid_q;
	logic [63:0] prod_q;
	logic        up_q;
	rap_pkg::rap_result_t result_q;

	logic                       item_fire;
	logic                       cfg_fire;
	logic [32:0]                sum;
	logic [31:0]                rnd_next;
	logic                       tick_run;
	logic                       trig;
	logic [rap_pkg::CNT_W-1:0]  cnt_sel;
	logic                       mod_busy;
	logic [rap_pkg::CNT_W-1:0]  mod_rem;
	rap_pkg::rap_gain_t         gain;

	logic                       note_we;
	logic                       scale_we;
	logic                       note_re;
	logic                       scale_re;
	logic [rap_pkg::NOTE_W-1:0] note_rdata;
	logic [31:0]                scale_rdata;
	logic                       idx_ok;
	logic                       fin_go;

	logic [4:0]                 shamt;
	logic [63:0]                shifted;
	logic [31:0]                sat;
	logic [31:0]                freq;

	assign item_ready = (state_q == ST_IDLE) && !gain.busy;
	assign item_fire  = item_valid && item_ready;
	assign cfg_ready  = 1'b1;
	assign cfg_fire   = cfg_valid && cfg_ready;

	// Phase accumulator; a carry out of the top bit is a trigger.
	assign sum      = {1'b0, phase_q} + {1'b0, tempo_inc_q};
	assign rnd_next = rap_pkg::rap_xorshift(rnd_q);
	assign tick_run = item_fire && (item.op == rap_pkg::OP_TICK) && (note_count_q >= 5'd2);
	assign trig     = tick_run && sum[32];

	// Note count clamped to the table depth.
	assign cnt_sel = (32'(note_count_q) < MAX_NOTES) ? note_count_q : rap_pkg::CNT_W'(MAX_NOTES);

	// Loads are only accepted while idle, so a table write never meets a trigger's read.
	assign note_we  = item_fire && (item.op == rap_pkg::OP_LOAD_NOTE) && (32'(item.slot) < MAX_NOTES);
	assign scale_we = item_fire && (item.op == rap_pkg::OP_LOAD_SCALE)
		&& (32'(item.slot) < MAX_SCALE);
	assign note_re  = (state_q == ST_MOD) && !mod_busy;

	// The scale index must be below both the programmed count and the table depth.
	assign idx_ok   = ({1'b0, note_rdata} < {2'b0, scale_count_q}) && (32'(note_rdata) < MAX_SCALE);
	assign scale_re = (state_q == ST_NOTE) && idx_ok;

	assign fin_go = (state_q == ST_FIN) && (!result_valid_q || result_ready);

	// Octave shift, saturation and the optional octave jump.
	assign shamt   = 5'd31 - 5'(gain.shift_n);
	assign shifted = prod_q >> shamt;
	assign sat     = (|shifted[63:32]) ? 32'hFFFF_FFFF : shifted[31:0];
	assign freq    = !up_q ? sat : (sat[31] ? 32'hFFFF_FFFF : {sat[30:0], 1'b0});

	rap_tables #(
		.MAX_NOTES (MAX_NOTES),
		.MAX_SCALE (MAX_SCALE),
		.NA_W      (NA_W),
		.SA_W      (SA_W)
	) u_tables (
		.clk         (clk),
		.note_we     (note_we),
		.note_waddr  (NA_W'(item.slot)),
		.note_wdata  (item.load_value[rap_pkg::NOTE_W-1:0]),
		.note_re     (note_re),
		.note_raddr  (NA_W'(mod_rem)),
		.note_rdata  (note_rdata),
		.scale_we    (scale_we),
		.scale_waddr (SA_W'(item.slot)),
		.scale_wdata (item.load_value),
		.scale_re    (scale_re),
		.scale_raddr (SA_W'(note_rdata)),
		.scale_rdata (scale_rdata)
	);

	rap_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig),
		.value   (rnd_next),
		.divisor (cnt_sel),
		.busy    (mod_busy),
		.rem     (mod_rem)
	);

	rap_gain #(
		.KNOB_BITS (KNOB_BITS)
	) u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (gain_go_q),
		.knob   (pitch_knob_q),
		.gain   (gain)
	);

	// Configuration registers. A knob write restarts the transpose factor unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_inc_q   <= rap_pkg::TEMPO_INC_RST;
			note_count_q  <= '0;
			scale_count_q <= '0;
			oct_thr_q     <= '0;
			pitch_knob_q  <= rap_pkg::PITCH_KNOB_RST;
			gain_go_q     <= 1'b1;
		end else begin
			gain_go_q <= 1'b0;
			if (cfg_fire) begin
				case (cfg_index)
					rap_pkg::CFG_TEMPO_INC:  tempo_inc_q   <= cfg_data;
					rap_pkg::CFG_NOTE_COUNT: note_count_q  <= cfg_data[rap_pkg::CNT_W-1:0];
					rap_pkg::CFG_SCALE_CNT:  scale_count_q <= cfg_data[6:0];
					rap_pkg::CFG_OCT_THRESH: oct_thr_q     <= cfg_data;
					rap_pkg::CFG_PITCH_KNOB: begin
						pitch_knob_q <= cfg_data[7:0];
						gain_go_q    <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Trigger sequencer, generator, phase and LED.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rnd_q          <= rap_pkg::RAND_SEED;
			phase_q        <= '0;
			led_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_run) begin
						phase_q <= sum[31:0];
					end
					if (trig) begin
						rnd_q   <= rnd_next;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (!mod_busy) begin
						state_q <= ST_NOTE;
					end
				end
				ST_NOTE: begin
					state_q <= idx_ok ? ST_SCALE : ST_IDLE;
				end
				ST_SCALE: begin
					rnd_q   <= rnd_next;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						led_q   <= ~led_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: scaled product, octave decision and the output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			prod_q <= 64'(scale_rdata) * 64'(gain.mult);
			up_q   <= (rnd_next < oct_thr_q);
		end
		if (fin_go) begin
			result_q.frequency <= freq;
			result_q.octave_up <= up_q;
			result_q.led_on    <= ~led_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A new result only ever comes out of the last sequencer step.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result appeared outside the final step");

	// The LED only toggles together with a result being loaded.
	a_led_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(led_q != $past(led_q)) |-> ($past(state_q) == ST_FIN && result_valid_q))
		else $error("LED toggled without a result");

	// A trigger starts only from an accepted request.
	a_trigger_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD && $past(state_q) == ST_IDLE) |-> $past(item_valid && item_ready))
		else $error("trigger started without an accepted request");

	// The remainder unit is idle whenever a request can be taken.
	a_mod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !mod_busy)
		else $error("remainder unit busy while accepting requests");

	// The user must not let the transpose factor change under a trigger in flight; the block does not enforce it.
	a_gain_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !gain.busy)
		else $error("transpose factor recomputed during a trigger");

endmodule
